FILE: hdl/buddy_block_allocator_macros.svh
// Assertion helpers for the buddy block allocator.
// Each macro assumes signals clk and rst_n in the using scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, ante, cons, msg)
`define BBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int MEM_ORDER_DEF   = 10;
  localparam int TABLE_DEPTH_DEF = 512;
  localparam int SIZE_W  = 11;
  localparam int REQ_W   = 8;
  localparam int NUM_W   = 10;
  localparam int ADDR_W  = 10;
  localparam int ORD_W   = 4;
  localparam int KORD_W  = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSIZE = 2'd1;
  localparam logic [1:0] ST_NOBLOCK = 2'd2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] size_request;
    logic [REQ_W-1:0]  requester_id;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NUM_W-1:0]  block_number;
    logic [ADDR_W-1:0] start_address;
    logic [ORD_W-1:0]  block_order;
  } out_t;

  typedef struct packed {
    logic              ok;
    logic [KORD_W-1:0] k;
  } size_dec_t;

endpackage
`default_nettype wire

FILE: hdl/bba_ram.sv
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bba_size_dec.sv
`default_nettype none
module bba_size_dec
  import bba_pkg::*;
#(
  parameter int MEM_ORDER = MEM_ORDER_DEF
) (
  input  wire logic [SIZE_W-1:0] size_request,
  output size_dec_t              dec
);

  logic [SIZE_W-1:0] m;

  always_comb begin
    m = size_request - SIZE_W'(1);
    dec.ok = (size_request >= SIZE_W'(2)) &&
             (32'(size_request) <= (32'd1 << MEM_ORDER));
    dec.k = '0;
    // ceiling log2: one above the top set bit of size minus one
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) begin
        dec.k = KORD_W'(i + 1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/buddy_block_allocator.sv
`default_nettype none
// Sequence: a bad size goes straight to the response; an allocate scans the whole table,
//   then per split seeks forward for a free entry (one entry a cycle) and makes two writes.
// Flow: one word at a time; the seeks of one allocate share one forward pass.
// Release all runs a clearing pass over all TABLE_DEPTH entries, then answers.
// Reset: synchronous, active low; the same clearing pass follows,
//   during which no input word is taken.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MEM_ORDER   = MEM_ORDER_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(MEM_ORDER + 1);
  localparam int MW = MEM_ORDER;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [OW-1:0]     order;
    logic [MW-1:0]     start;
    logic [NUM_W-1:0]  number;
    logic [REQ_W-1:0]  requester;
  } ent_t;

  localparam int EW = $bits(ent_t);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_SEEK   = 9'b000010000,
    S_WR_LO  = 9'b000100000,
    S_WR_UP  = 9'b001000000,
    S_GRANT  = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic rel_r, rel_nxt;
  logic [AW-1:0] iss_idx_r, iss_idx_nxt;
  logic iss_done_r, iss_done_nxt;
  logic rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [OW-1:0] k_r, k_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic found_r, found_nxt;
  logic [OW-1:0] best_ord_r, best_ord_nxt;
  logic [MW-1:0] best_start_r, best_start_nxt;
  logic [NUM_W-1:0] best_num_r, best_num_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [AW:0] spare_r, spare_nxt;
  logic [AW-1:0] cur_idx_r, cur_idx_nxt;
  logic [OW-1:0] cur_ord_r, cur_ord_nxt;
  logic [MW-1:0] cur_start_r, cur_start_nxt;
  logic [NUM_W-1:0] cur_num_r, cur_num_nxt;
  logic [AW-1:0] up_idx_r, up_idx_nxt;
  logic [NUM_W-1:0] nbn_r, nbn_nxt;
  out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic rd_en, we;
  logic [AW-1:0] waddr;
  ent_t wdata, rdata;
  size_dec_t dec;
  logic [OW-1:0] half;
  logic [31:0] start_ext, ord_ext;

  bba_size_dec #(.MEM_ORDER(MEM_ORDER)) u_dec (
    .size_request(in_data.size_request),
    .dec         (dec)
  );

  bba_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(iss_idx_r),
    .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_en = ((state_r == S_SCAN) && !iss_done_r) || (state_r == S_SEEK);
  assign half = cur_ord_r - OW'(1);
  assign start_ext = 32'(cur_start_r);
  assign ord_ext = 32'(cur_ord_r);

  // table write port
  always_comb begin
    we = 1'b0;
    waddr = cur_idx_r;
    wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_idx_r;
        if (clr_idx_r == '0) begin
          wdata.valid = 1'b1;
          wdata.free  = 1'b1;
          wdata.order = OW'(MEM_ORDER);
        end
      end
      S_WR_LO: begin
        we = 1'b1;
        wdata.valid  = 1'b1;
        wdata.free   = 1'b1;
        wdata.order  = half;
        wdata.start  = cur_start_r;
        wdata.number = nbn_r;
      end
      S_WR_UP: begin
        we = 1'b1;
        waddr = up_idx_r;
        wdata.valid  = 1'b1;
        wdata.free   = 1'b1;
        wdata.order  = half;
        wdata.start  = cur_start_r + (MW'(1) << half);
        wdata.number = nbn_r;
      end
      S_GRANT: begin
        we = 1'b1;
        wdata.valid     = 1'b1;
        wdata.order     = cur_ord_r;
        wdata.start     = cur_start_r;
        wdata.number    = cur_num_r;
        wdata.requester = req_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_idx_nxt = clr_idx_r;
    rel_nxt = rel_r;
    iss_idx_nxt = iss_idx_r;
    iss_done_nxt = iss_done_r;
    k_nxt = k_r;
    req_nxt = req_r;
    found_nxt = found_r;
    best_ord_nxt = best_ord_r;
    best_start_nxt = best_start_r;
    best_num_nxt = best_num_r;
    best_idx_nxt = best_idx_r;
    spare_nxt = spare_r;
    cur_idx_nxt = cur_idx_r;
    cur_ord_nxt = cur_ord_r;
    cur_start_nxt = cur_start_r;
    cur_num_nxt = cur_num_r;
    up_idx_nxt = up_idx_r;
    nbn_nxt = nbn_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data.requester_id;
          k_nxt = OW'(dec.k);
          res_nxt = '0;
          if (in_data.mode == MODE_RELEASE) begin
            clr_idx_nxt = '0;
            rel_nxt = 1'b1;
            nbn_nxt = NUM_W'(1);
            state_nxt = S_CLEAR;
          end else if (!dec.ok) begin
            res_nxt.status = ST_BADSIZE;
            state_nxt = S_RESP;
          end else begin
            iss_idx_nxt = '0;
            iss_done_nxt = 1'b0;
            found_nxt = 1'b0;
            spare_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == LAST) begin
          state_nxt = rel_r ? S_RESP : S_IDLE;
        end
      end
      S_SCAN: begin
        if (!iss_done_r) begin
          iss_idx_nxt = iss_idx_r + AW'(1);
          iss_done_nxt = (iss_idx_r == LAST);
        end
        if (rd_vld_r) begin
          if (!rdata.valid) begin
            spare_nxt = spare_r + (AW+1)'(1);
          end else if (rdata.free && (rdata.order >= k_r) &&
                       (!found_r || (rdata.order < best_ord_r) ||
                        ((rdata.order == best_ord_r) && (rdata.number < best_num_r)))) begin
            found_nxt = 1'b1;
            best_ord_nxt = rdata.order;
            best_start_nxt = rdata.start;
            best_num_nxt = rdata.number;
            best_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == LAST) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cur_idx_nxt = best_idx_r;
        cur_ord_nxt = best_ord_r;
        cur_start_nxt = best_start_r;
        cur_num_nxt = best_num_r;
        iss_idx_nxt = '0;
        if (!found_r || (32'(spare_r) < (32'(best_ord_r) - 32'(k_r)))) begin
          res_nxt.status = ST_NOBLOCK;
          state_nxt = S_RESP;
        end else if (best_ord_r == k_r) begin
          state_nxt = S_GRANT;
        end else begin
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        iss_idx_nxt = iss_idx_r + AW'(1);
        if (rd_vld_r && !rdata.valid) begin
          up_idx_nxt = rd_idx_r;
          state_nxt = S_WR_LO;
        end
      end
      S_WR_LO: begin
        nbn_nxt = nbn_r + NUM_W'(1);
        state_nxt = S_WR_UP;
      end
      S_WR_UP: begin
        nbn_nxt = nbn_r + NUM_W'(1);
        cur_ord_nxt = half;
        iss_idx_nxt = up_idx_r + AW'(1);
        if (half == k_r) begin
          // grant the lower half, numbered by the write before
          cur_num_nxt = nbn_r - NUM_W'(1);
          state_nxt = S_GRANT;
        end else begin
          cur_idx_nxt = up_idx_r;
          cur_start_nxt = cur_start_r + (MW'(1) << half);
          cur_num_nxt = nbn_r;
          state_nxt = S_SEEK;
        end
      end
      S_GRANT: begin
        res_nxt.status = ST_OK;
        res_nxt.block_number = cur_num_r;
        res_nxt.start_address = start_ext[ADDR_W-1:0];
        res_nxt.block_order = ord_ext[ORD_W-1:0];
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_idx_r <= '0;
      rel_r <= 1'b0;
      iss_done_r <= 1'b1;
      rd_vld_r <= 1'b0;
      found_r <= 1'b0;
      nbn_r <= NUM_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      rel_r <= rel_nxt;
      iss_done_r <= iss_done_nxt;
      rd_vld_r <= rd_en;
      found_r <= found_nxt;
      nbn_r <= nbn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r <= iss_idx_nxt;
    rd_idx_r <= iss_idx_r;
    k_r <= k_nxt;
    req_r <= req_nxt;
    best_ord_r <= best_ord_nxt;
    best_start_r <= best_start_nxt;
    best_num_r <= best_num_nxt;
    best_idx_r <= best_idx_nxt;
    spare_r <= spare_nxt;
    cur_idx_r <= cur_idx_nxt;
    cur_ord_r <= cur_ord_nxt;
    cur_start_r <= cur_start_nxt;
    cur_num_r <= cur_num_nxt;
    up_idx_r <= up_idx_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `BBA_ASSERT_IMP(a_up_after_lo, state_r == S_WR_UP, $past(state_r) == S_WR_LO, "upper half write without lower half")
  `BBA_ASSERT_NXT(a_num_step, state_r == S_WR_UP, nbn_r == $past(nbn_r) + NUM_W'(1), "block counter step lost")
  `BBA_ASSERT_IMP(a_no_take_clear, state_r == S_CLEAR, !in_ready, "word taken during clearing pass")
  `BBA_ASSERT_IMP(a_split_order, state_r == S_WR_LO, cur_ord_r > k_r, "split below requested order")

endmodule
`default_nettype wire
